@@ design/sktu_pkg.sv @@
// Package for the sorted key table upsert block.
// Holds the request and result types, status codes and controller states.
// No dependencies.
package sktu_pkg;

  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 32;
  localparam int SLOT_BITS    = 5;
  localparam int COUNT_BITS   = 5;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REPLACED = 2'd1,
    ST_ZERO_KEY = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]     entry_key;
    logic [PAYLOAD_BITS-1:0] entry_payload;
  } in_req_t;

  typedef struct packed {
    status_t                status;
    logic [SLOT_BITS-1:0]   slot;
    logic [COUNT_BITS-1:0]  entry_count;
  } out_res_t;

  typedef struct packed {
    logic key;
    logic pay;
  } mem_we_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_RESPOND
  } state_t;

endpackage

@@ design/sorted_key_table_upsert.sv @@
// Sorted key table upsert, top level: controller, key and payload memories, result register.
// Uses sktu_pkg, sktu_mem and sktu_ctrl.
// One request at a time; busy is high from acceptance until the result is issued.
// Steps: binary search (up to log2(count)+1 steps), a match check if it ends in the table,
// then, for a new key and room left, entries moved up and an insert; a zero key skips all.
// Reset empties the table; the result strobe is one cycle wide and cannot be stalled.
module sorted_key_table_upsert #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sktu_pkg::in_req_t  in_data,
  output logic               out_valid,
  output sktu_pkg::out_res_t out_data
);
  import sktu_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  mem_we_t                 we;
  logic [AW-1:0]           waddr, raddr;
  logic [KEY_BITS-1:0]     wkey, rkey;
  logic [PAYLOAD_BITS-1:0] wpay, rpay;
  logic                    done;
  out_res_t                res;
  logic [CW-1:0]           count;
  logic                    out_valid_r;
  out_res_t                out_data_r;

  sktu_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .req   (in_data),
    .busy  (busy),
    .done  (done),
    .res   (res),
    .count (count),
    .we    (we),
    .waddr (waddr),
    .raddr (raddr),
    .wkey  (wkey),
    .wpay  (wpay),
    .rkey  (rkey),
    .rpay  (rpay)
  );

  sktu_mem #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_key_mem (
    .clk   (clk),
    .we    (we.key),
    .waddr (waddr),
    .wdata (wkey),
    .raddr (raddr),
    .rdata (rkey)
  );

  sktu_mem #(.WIDTH(PAYLOAD_BITS), .DEPTH(DEPTH)) u_pay_mem (
    .clk   (clk),
    .we    (we.pay),
    .waddr (waddr),
    .wdata (wpay),
    .raddr (raddr),
    .rdata (rpay)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted without entering busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CW'(DEPTH))
    else $error("entry count exceeds table depth");

  a_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_ZERO_KEY) |-> (out_data.slot == '0))
    else $error("zero key result with nonzero slot");

endmodule

@@ design/sktu_mem.sv @@
// Single-port-write, single-port-read synchronous RAM for the table.
// Read data is registered and appears in the cycle after the address. No dependencies.
module sktu_mem #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/sktu_ctrl.sv @@
// Controller for the sorted key table: binary search, entry shift and write-back.
// Uses sktu_pkg; drives the key and payload memories.
module sktu_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  sktu_pkg::in_req_t                      req,
  output logic                                   busy,
  output logic                                   done,
  output sktu_pkg::out_res_t                     res,
  output logic [$clog2(DEPTH+1)-1:0]             count,
  output sktu_pkg::mem_we_t                      we,
  output logic [$clog2(DEPTH)-1:0]               waddr,
  output logic [$clog2(DEPTH)-1:0]               raddr,
  output logic [sktu_pkg::KEY_BITS-1:0]          wkey,
  output logic [sktu_pkg::PAYLOAD_BITS-1:0]      wpay,
  input  logic [sktu_pkg::KEY_BITS-1:0]          rkey,
  input  logic [sktu_pkg::PAYLOAD_BITS-1:0]      rpay
);
  import sktu_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  state_t                  state_r, state_nxt;
  logic [KEY_BITS-1:0]     key_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [CW-1:0]           lo_r, hi_r, mid_r, idx_r, count_r;
  status_t                 status_r;
  logic [CW-1:0]           mid, idx_m1;
  logic                    found, full;

  assign mid    = lo_r + ((hi_r - lo_r) >> 1);
  assign idx_m1 = idx_r - 1'b1;
  assign found  = (rkey == key_r);
  assign full   = (count_r == FULL_COUNT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (req.entry_key == '0) ? S_RESPOND : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (lo_r < hi_r) begin
          state_nxt = S_CMP;
        end else if (lo_r < count_r) begin
          state_nxt = S_CHECK;
        end else if (full) begin
          state_nxt = S_RESPOND;
        end else begin
          state_nxt = S_INSERT;
        end
      end
      S_CMP:      state_nxt = S_SEARCH;
      S_CHECK: begin
        if (found || full) begin
          state_nxt = S_RESPOND;
        end else begin
          state_nxt = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = (idx_m1 == lo_r) ? S_INSERT : S_SHIFT_RD;
      S_INSERT:   state_nxt = S_RESPOND;
      S_RESPOND:  state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy  = (state_r != S_IDLE);
    done  = 1'b0;
    we    = '0;
    waddr = lo_r[AW-1:0];
    raddr = lo_r[AW-1:0];
    wkey  = key_r;
    wpay  = pay_r;
    unique case (state_r)
      S_SEARCH: begin
        if (lo_r < hi_r) begin
          raddr = mid[AW-1:0];
        end
      end
      S_CHECK: begin
        if (found) begin
          we.pay = 1'b1;
        end
      end
      S_SHIFT_RD: raddr = idx_m1[AW-1:0];
      S_SHIFT_WR: begin
        we    = '{key: 1'b1, pay: 1'b1};
        waddr = idx_r[AW-1:0];
        wkey  = rkey;
        wpay  = rpay;
      end
      S_INSERT:  we = '{key: 1'b1, pay: 1'b1};
      S_RESPOND: done = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_INSERT) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        key_r    <= req.entry_key;
        pay_r    <= req.entry_payload;
        lo_r     <= '0;
        hi_r     <= count_r;
        status_r <= ST_ZERO_KEY;
      end
      S_SEARCH: begin
        mid_r <= mid;
        if (!(lo_r < hi_r) && !(lo_r < count_r)) begin
          status_r <= full ? ST_FULL : ST_INSERTED;
        end
      end
      S_CMP: begin
        if (rkey >= key_r) begin
          hi_r <= mid_r;
        end else begin
          lo_r <= mid_r + 1'b1;
        end
      end
      S_CHECK: begin
        idx_r <= count_r;
        if (found) begin
          status_r <= ST_REPLACED;
        end else if (full) begin
          status_r <= ST_FULL;
        end else begin
          status_r <= ST_INSERTED;
        end
      end
      S_SHIFT_WR: idx_r <= idx_m1;
      default: begin
      end
    endcase
  end

  assign res.status      = status_r;
  assign res.slot        = SLOT_BITS'(lo_r);
  assign res.entry_count = COUNT_BITS'(count_r);
  assign count           = count_r;

endmodule
